FILE: sv/trnh_pkg.sv
`default_nettype none
package trnh_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_SUBTREE = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_OWN_ID    = 1'b0;
  localparam logic CFG_PARENT_ID = 1'b1;

  // Largest id that a table entry can hold
  localparam logic [7:0] ID_MAX = 8'd63;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] node_id;
    logic [7:0] parent_value;
    logic [5:0] root_id;
  } trnh_in_t;

  typedef struct packed {
    logic [5:0] next_hop;
    logic       in_subtree;
    logic       used_default;
  } trnh_out_t;

  // Table update request from the sequencer
  typedef struct packed {
    logic       en;
    logic       clr;
    logic [5:0] node;
    logic [7:0] value;
  } trnh_wr_t;

  // Registered table read result
  typedef struct packed {
    logic       inv;
    logic [5:0] id;
  } trnh_rd_t;

endpackage
`default_nettype wire

FILE: sv/trnh_table.sv
`default_nettype none
module trnh_table import trnh_pkg::*; #(
  parameter int NUM_NODES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire trnh_wr_t   wr,
  input  wire logic [5:0] rd_node,
  output trnh_rd_t        rd
);

  localparam int TBL_DEPTH = (NUM_NODES < 64) ? NUM_NODES : 64;
  localparam int IDX_W     = $clog2(TBL_DEPTH);

  logic [5:0]           mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  logic [5:0]           rd_id_r;
  logic                 rd_inv_r;

  logic             wr_in_range;
  logic             rd_in_range;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_in_range = (32'(wr.node) < NUM_NODES);
  assign rd_in_range = (32'(rd_node) < NUM_NODES);
  assign wr_idx      = wr.node[IDX_W-1:0];
  assign rd_idx      = rd_node[IDX_W-1:0];

  // Mark an entry valid on write of an id up to ID_MAX, else invalid; drop all marks on clear or reset
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clr) begin
      vld_r <= '0;
    end else if (wr.en && wr_in_range) begin
      vld_r[wr_idx] <= (wr.value <= ID_MAX);
    end
  end

  // Store parent ids and register one read per cycle
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_idx] <= wr.value[5:0];
    end
    rd_id_r  <= mem[rd_idx];
    rd_inv_r <= !(rd_in_range && vld_r[rd_idx]);
  end

  assign rd.inv = rd_inv_r;
  assign rd.id  = rd_id_r;

endmodule
`default_nettype wire

FILE: sv/tree_route_next_hop_table.sv
// Write and clear transactions need no table walk; lookup and subtree test climb at most
// NUM_NODES parent entries, one table read per cycle through the single read port of the
// parent table. One transaction is in work at a time. A finished result goes to the output
// register when it is free; else it is parked and new transactions stall until it moves on.
// Synchronous active-low reset: own_id and parent_id go to 0, every table entry reads
// invalid right after reset (per-entry valid bits, no clearing pass).
`default_nettype none
module tree_route_next_hop_table import trnh_pkg::*; #(
  parameter int NUM_NODES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire trnh_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output trnh_out_t       out_data
);

  localparam int CNT_W = $clog2(NUM_NODES + 1);
  localparam logic [CNT_W-1:0] STEP_LIMIT = CNT_W'(NUM_NODES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic             sub_r, sub_nxt;
  logic [5:0]       cur_r, cur_nxt;
  logic [5:0]       root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  trnh_out_t        res_r, res_nxt;
  logic [5:0]       own_r, parent_r;
  logic             out_valid_r;
  trnh_out_t        out_data_r;

  logic      in_acc;
  logic      slot_free;
  logic      done;
  logic      load;
  trnh_out_t res;
  trnh_out_t load_data;
  trnh_wr_t  wr;
  trnh_rd_t  rd;
  logic [5:0] rd_node;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  // Table update on write and clear transactions
  assign wr.en    = in_acc && (in_data.op == OP_WRITE);
  assign wr.clr   = in_acc && (in_data.op == OP_CLEAR);
  assign wr.node  = in_data.node_id;
  assign wr.value = in_data.parent_value;

  // Start from the destination, then follow the last parent read
  assign rd_node = (state_r == ST_IDLE) ? in_data.node_id : rd.id;

  trnh_table #(
    .NUM_NODES(NUM_NODES)
  ) u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_node(rd_node),
    .rd     (rd)
  );

  // Sequencer: one climb step per cycle
  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    cur_nxt   = cur_r;
    root_nxt  = root_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    done      = 1'b0;
    res       = '0;
    load      = 1'b0;
    load_data = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.op)
            OP_LOOKUP: begin
              if (in_data.node_id == '0) begin
                done             = 1'b1;
                res.next_hop     = parent_r;
                res.used_default = 1'b1;
              end else if (in_data.node_id == own_r) begin
                done         = 1'b1;
                res.next_hop = own_r;
              end else begin
                state_nxt = ST_WALK;
                sub_nxt   = 1'b0;
                cur_nxt   = in_data.node_id;
                cnt_nxt   = CNT_W'(1);
              end
            end
            OP_SUBTREE: begin
              if (in_data.node_id == in_data.root_id) begin
                done           = 1'b1;
                res.in_subtree = 1'b1;
              end else begin
                state_nxt = ST_WALK;
                sub_nxt   = 1'b1;
                root_nxt  = in_data.root_id;
                cur_nxt   = in_data.node_id;
                cnt_nxt   = CNT_W'(1);
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (sub_r) begin
          if (rd.inv || (cnt_r == STEP_LIMIT)) begin
            done = 1'b1;
          end else if (rd.id == root_r) begin
            done           = 1'b1;
            res.in_subtree = 1'b1;
          end else begin
            cur_nxt = rd.id;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          if (rd.inv) begin
            done             = 1'b1;
            res.next_hop     = parent_r;
            res.used_default = 1'b1;
          end else if (rd.id == own_r) begin
            done         = 1'b1;
            res.next_hop = cur_r;
          end else if (cnt_r == STEP_LIMIT) begin
            done             = 1'b1;
            res.next_hop     = parent_r;
            res.used_default = 1'b1;
          end else begin
            cur_nxt = rd.id;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          load      = 1'b1;
          load_data = res_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Hand a finished result to the output register, or park it
    if (done) begin
      if (slot_free) begin
        load      = 1'b1;
        load_data = res;
        state_nxt = ST_IDLE;
      end else begin
        res_nxt   = res;
        state_nxt = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sub_r  <= sub_nxt;
    cur_r  <= cur_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r    <= '0;
      parent_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_OWN_ID:    own_r    <= cfg_data;
        CFG_PARENT_ID: parent_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
